/* hw/rtl/rsnh_pkg.sv */
package rsnh_pkg;

  localparam int CMD_W   = 1;
  localparam int INDEX_W = 4;
  localparam int CFG_W   = 5;
  localparam int DIST_W  = 28;

  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CAST = 1'b1;

  localparam logic [CFG_W-1:0]  ACTIVE_RESET = 5'd9;
  localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};

endpackage

/* hw/rtl/rsnh_table.sv */
module rsnh_table #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 52
) (
  input  logic                                      clk_i,
  input  logic                                      wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]                         wr_data_i,
  input  logic                                      rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]                         rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/rsnh_round.sv */
// round_half_away(p + d * tn / den), 0 <= tn <= den, den > 0
// one quotient bit per cycle, then a fix-up step and a rounding step
module rsnh_round #(
  parameter int COORD_BITS = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [COORD_BITS-1:0]  p_i,
  input  logic signed [COORD_BITS:0]    d_i,
  input  logic [2*COORD_BITS+2:0]       tn_i,
  input  logic [2*COORD_BITS+2:0]       den_i,
  output logic                          done_o,
  output logic signed [COORD_BITS-1:0]  res_o
);

  localparam int CP = COORD_BITS + 1;
  localparam int DW = 2 * COORD_BITS + 3;
  localparam int RW = DW + 1;
  localparam int BW = COORD_BITS + 2;
  localparam int KW = $clog2(COORD_BITS + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIX  = 2'd2;
  localparam logic [1:0] D_RND  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [KW-1:0]                k_q;
  logic [CP-1:0]                a_q;
  logic                         neg_q;
  logic signed [COORD_BITS-1:0] p_q;
  logic [DW-1:0]                tn_q, den_q;
  logic [CP-1:0]                q_q;
  logic [DW-1:0]                r_q;
  logic signed [BW-1:0]         base_q;
  logic                         done_q;
  logic signed [COORD_BITS-1:0] res_q;

  logic [RW-1:0]        r2, r2_m1, r2_m2, den_x1, den_x2;
  logic [CP-1:0]        q_next;
  logic [DW-1:0]        r_next;
  logic signed [BW-1:0] q_s, base_fix;
  logic [RW-1:0]        r_dbl;
  logic                 up;

  always_comb begin
    den_x1 = RW'(den_q);
    den_x2 = {den_q, 1'b0};
    r2     = {r_q, 1'b0} + (a_q[k_q] ? RW'(tn_q) : '0);
    r2_m1  = r2 - den_x1;
    r2_m2  = r2 - den_x2;
    if (r2 >= den_x2) begin
      r_next = r2_m2[DW-1:0];
      q_next = {q_q[CP-2:0], 1'b0} + CP'(2);
    end else if (r2 >= den_x1) begin
      r_next = r2_m1[DW-1:0];
      q_next = {q_q[CP-2:0], 1'b0} + CP'(1);
    end else begin
      r_next = r2[DW-1:0];
      q_next = {q_q[CP-2:0], 1'b0};
    end
    q_s = $signed({1'b0, q_q});
    if (neg_q) begin
      base_fix = BW'(p_q) - q_s - ((r_q != '0) ? BW'(1) : BW'(0));
    end else begin
      base_fix = BW'(p_q) + q_s;
    end
    r_dbl = {r_q, 1'b0};
    up    = (base_q >= 0) ? (r_dbl >= den_x1) : (r_dbl > den_x1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE:  if (start_i) state_d = D_RUN;
      D_RUN:   if (k_q == '0) state_d = D_FIX;
      D_FIX:   state_d = D_RND;
      D_RND:   state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == D_RND);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          a_q   <= d_i[CP-1] ? CP'(-d_i) : CP'(d_i);
          neg_q <= d_i[CP-1];
          p_q   <= p_i;
          tn_q  <= tn_i;
          den_q <= den_i;
          q_q   <= '0;
          r_q   <= '0;
          k_q   <= KW'(COORD_BITS);
        end
      end
      D_RUN: begin
        q_q <= q_next;
        r_q <= r_next;
        k_q <= k_q - KW'(1);
      end
      D_FIX: begin
        base_q <= base_fix;
        if (neg_q && r_q != '0) begin
          r_q <= den_q - r_q;
        end
      end
      D_RND: begin
        res_q <= COORD_BITS'(base_q + (up ? BW'(1) : BW'(0)));
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hw/rtl/ray_segment_nearest_hit_top.sv */
// Nearest-hit ray caster over a table of wall segments. A load item (command 0)
// writes one segment into the table and gives no result; a load whose index
// is not below MAX_SEGMENTS is dropped. A cast item (command 1) tests the ray
// from (first_x, first_y) to (second_x, second_y) against entries
// 0 .. min(active_segments, MAX_SEGMENTS)-1 and returns one result: the
// nearest crossing, rounded half away from zero, with its squared distance
// (saturating at 2^28-1), or the ray end with hit clear. On equal distance
// the lower entry wins. Entries must be loaded before a cast reads them.
// Each test runs six products through one shared multiplier, and each
// crossing runs the serial rounding divider once per axis. Items are taken
// one at a time; a finished result sits in the output register while the
// next item is accepted.
module ray_segment_nearest_hit_top #(
  parameter int MAX_SEGMENTS = 16,
  parameter int COORD_BITS   = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsnh_pkg::CFG_W-1:0]    active_segments_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rsnh_pkg::CMD_W-1:0]    command_i,
  input  logic [rsnh_pkg::INDEX_W-1:0]  segment_index_i,
  input  logic signed [COORD_BITS-1:0]  first_x_i,
  input  logic signed [COORD_BITS-1:0]  first_y_i,
  input  logic signed [COORD_BITS-1:0]  second_x_i,
  input  logic signed [COORD_BITS-1:0]  second_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [COORD_BITS-1:0]  point_x_o,
  output logic signed [COORD_BITS-1:0]  point_y_o,
  output logic [rsnh_pkg::DIST_W-1:0]   square_distance_o
);

  import rsnh_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int CP  = C + 1;
  localparam int PW  = 2 * C + 2;
  localparam int DW  = 2 * C + 3;
  localparam int DSW = 2 * C + 1;
  localparam int SW  = (DSW > DIST_W) ? DSW : DIST_W;
  localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int NW  = $clog2(MAX_SEGMENTS + 1);
  localparam int EW  = 4 * C;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_FIX  = 4'd3;
  localparam logic [3:0] S_TEST = 4'd4;
  localparam logic [3:0] S_DXGO = 4'd5;
  localparam logic [3:0] S_DXW  = 4'd6;
  localparam logic [3:0] S_DYGO = 4'd7;
  localparam logic [3:0] S_DYW  = 4'd8;
  localparam logic [3:0] S_SQ   = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]           state_q, state_d;
  logic [CFG_W-1:0]     active_q;
  logic [NW-1:0]        cnt_q, i_q;
  logic [2:0]           m_q;
  logic signed [C-1:0]  x1_q, y1_q, x2_q, y2_q;
  logic signed [C-1:0]  px_q, py_q, bx_q, by_q;
  logic signed [PW-1:0] prod_q;
  logic signed [DW-1:0] den_q, tn_q, un_q;
  logic [DSW-1:0]       dist_q, best_q;
  logic                 found_q;
  logic                 out_valid_q, hit_q;
  logic signed [C-1:0]  out_x_q, out_y_q;
  logic [DIST_W-1:0]    out_d_q;

  logic                 accept, load_ok, out_free, div_done;
  logic [EW-1:0]        rd_data;
  logic signed [C-1:0]  x3, y3, x4, y4, div_res;
  logic signed [CP-1:0] dx12, dy12, dx34, dy34, dx13, dy13, ex, ey;
  logic signed [CP-1:0] mul_a, mul_b, div_d;
  logic signed [C-1:0]  div_p;
  logic                 reject;
  logic [SW-1:0]        best_ext;
  logic [DIST_W-1:0]    dist_sat;
  logic [31:0]          active_ext;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load_ok     = (32'(segment_index_i) < 32'(MAX_SEGMENTS));
  assign out_free    = !out_valid_q || out_ready_i;
  assign active_ext  = 32'(active_q);

  rsnh_table #(
    .DEPTH (MAX_SEGMENTS),
    .DATA_W(EW)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (accept && command_i == CMD_LOAD && load_ok),
    .wr_addr_i(IW'(segment_index_i)),
    .wr_data_i({first_x_i, first_y_i, second_x_i, second_y_i}),
    .rd_en_i  (state_q == S_READ),
    .rd_addr_i(IW'(i_q)),
    .rd_data_o(rd_data)
  );

  assign x3 = rd_data[4*C-1:3*C];
  assign y3 = rd_data[3*C-1:2*C];
  assign x4 = rd_data[2*C-1:C];
  assign y4 = rd_data[C-1:0];

  always_comb begin
    dx12 = CP'(x1_q) - CP'(x2_q);
    dy12 = CP'(y1_q) - CP'(y2_q);
    dx34 = CP'(x3) - CP'(x4);
    dy34 = CP'(y3) - CP'(y4);
    dx13 = CP'(x1_q) - CP'(x3);
    dy13 = CP'(y1_q) - CP'(y3);
    ex   = CP'(px_q) - CP'(x1_q);
    ey   = CP'(py_q) - CP'(y1_q);
  end

  // one shared multiplier, operands picked by phase
  always_comb begin
    mul_a = ex;
    mul_b = ex;
    if (state_q == S_MUL) begin
      case (m_q)
        3'd0:    begin mul_a = dx12; mul_b = dy34; end
        3'd1:    begin mul_a = dy12; mul_b = dx34; end
        3'd2:    begin mul_a = dx13; mul_b = dy34; end
        3'd3:    begin mul_a = dy13; mul_b = dx34; end
        3'd4:    begin mul_a = dy12; mul_b = dx13; end
        default: begin mul_a = dx12; mul_b = dy13; end
      endcase
    end else if (m_q != 3'd0) begin
      mul_a = ey;
      mul_b = ey;
    end
  end

  assign div_p = (state_q == S_DXGO) ? x1_q : y1_q;
  assign div_d = (state_q == S_DXGO) ? (CP'(x2_q) - CP'(x1_q)) : (CP'(y2_q) - CP'(y1_q));

  rsnh_round #(
    .COORD_BITS(COORD_BITS)
  ) u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_DXGO || state_q == S_DYGO),
    .p_i    (div_p),
    .d_i    (div_d),
    .tn_i   (tn_q),
    .den_i  (den_q),
    .done_o (div_done),
    .res_o  (div_res)
  );

  assign reject = (tn_q < 0) || (tn_q > den_q) || (un_q < 0) || (un_q > den_q);

  assign best_ext = SW'(best_q);
  assign dist_sat = (best_ext > SW'(DIST_MAX)) ? DIST_MAX : best_ext[DIST_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && command_i == CMD_CAST) state_d = S_READ;
      S_READ:  state_d = (i_q == cnt_q) ? S_DONE : S_MUL;
      S_MUL:   if (m_q == 3'd6) state_d = S_FIX;
      S_FIX:   state_d = (den_q == '0) ? S_READ : S_TEST;
      S_TEST:  state_d = reject ? S_READ : S_DXGO;
      S_DXGO:  state_d = S_DXW;
      S_DXW:   if (div_done) state_d = S_DYGO;
      S_DYGO:  state_d = S_DYW;
      S_DYW:   if (div_done) state_d = S_SQ;
      S_SQ:    if (m_q == 3'd2) state_d = S_CMP;
      S_CMP:   state_d = S_READ;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= ACTIVE_RESET;
      out_valid_q <= 1'b0;
      m_q         <= '0;
      i_q         <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= active_segments_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == S_MUL && m_q != 3'd6) || (state_q == S_SQ && m_q != 3'd2)) begin
        m_q <= m_q + 3'd1;
      end else begin
        m_q <= '0;
      end
      if (state_q == S_IDLE) begin
        i_q     <= '0;
        found_q <= 1'b0;
        cnt_q   <= (active_ext > 32'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS) : NW'(active_q);
      end else if (state_q == S_READ && i_q != cnt_q) begin
        i_q <= i_q + NW'(1);
      end
      if (state_q == S_CMP && (!found_q || dist_q < best_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      x1_q <= first_x_i;
      y1_q <= first_y_i;
      x2_q <= second_x_i;
      y2_q <= second_y_i;
    end
    if (state_q == S_MUL) begin
      case (m_q)
        3'd1:    den_q <= DW'(prod_q);
        3'd2:    den_q <= den_q - DW'(prod_q);
        3'd3:    tn_q  <= DW'(prod_q);
        3'd4:    tn_q  <= tn_q - DW'(prod_q);
        3'd5:    un_q  <= DW'(prod_q);
        3'd6:    un_q  <= un_q - DW'(prod_q);
        default: ;
      endcase
    end
    // fold the sign of the denominator into both numerators
    if (state_q == S_FIX && den_q < 0) begin
      den_q <= -den_q;
      tn_q  <= -tn_q;
      un_q  <= -un_q;
    end
    if (state_q == S_DXW && div_done) begin
      px_q <= div_res;
    end
    if (state_q == S_DYW && div_done) begin
      py_q <= div_res;
    end
    if (state_q == S_SQ) begin
      if (m_q == 3'd1) begin
        dist_q <= DSW'(prod_q);
      end else if (m_q == 3'd2) begin
        dist_q <= dist_q + DSW'(prod_q);
      end
    end
    if (state_q == S_CMP && (!found_q || dist_q < best_q)) begin
      best_q <= dist_q;
      bx_q   <= px_q;
      by_q   <= py_q;
    end
    if (state_q == S_DONE && out_free) begin
      hit_q   <= found_q;
      out_x_q <= found_q ? bx_q : x2_q;
      out_y_q <= found_q ? by_q : y2_q;
      out_d_q <= found_q ? dist_sat : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = hit_q;
  assign point_x_o         = out_x_q;
  assign point_y_o         = out_y_q;
  assign square_distance_o = out_d_q;

endmodule
